### hdl/waypoint_patrol_sequencer_unit_macros.svh
// assertion macros used by the port-level checker of the patrol sequencer
`ifndef WAYPOINT_PATROL_SEQUENCER_UNIT_MACROS_SVH
`define WAYPOINT_PATROL_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define WPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wps_pkg.sv
// types and constants of the patrol waypoint sequencer
`default_nettype none

package wps_pkg;

  // stream widths
  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_ADDR_W-1:0] CFG_ARRIVAL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT   = 1'b1;

  localparam logic [39:0] ARRIVAL_RESET = 40'h01_0000_0000;
  localparam logic [4:0]  COUNT_RESET   = 5'd10;

  // (10000 m)^2 in Q32.32
  localparam logic [63:0] SCAN_START_SQ = 64'd100000000 << 32;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_GOAL = 2'd1,
    ACT_POSE = 2'd2,
    ACT_TICK = 2'd3
  } wps_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH
  } wps_state_t;

endpackage

`default_nettype wire

### hdl/wps_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module wps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/waypoint_patrol_sequencer_unit.sv
// patrol waypoint sequencer top level: waypoint ram, distance pipe and control
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | in_tuser action, in_tdata slot/pose/orientation
//  out_    | out | out_tvalid/out_tready | out_tdata goal pose, orientation, slot
//  cfg_    | in  | cfg_wr_en           | cfg_addr register index, cfg_wdata value
//
// load, set goal and pose update are handled in the idle state
// a tick runs the distance pipe (abs diff, square, saturating add); when
// not arrived it goes back to idle, else it fetches the next waypoint; the first
// emission follows a nearest-entry scan that streams one ram entry per cycle
// reset is synchronous; the waypoint table itself is not cleared
// a result waiting on out_tready stalls only the next emitting tick
`default_nettype none

module waypoint_patrol_sequencer_unit
  import wps_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // action
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  // slot, pos_x, pos_y, orient_z, orient_w, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // goal_x, goal_y, goal_z, goal_w, goal_slot, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int WR_W  = IDX_W + 1;
  localparam int ENT_W = 96;

  // input fields
  logic [3:0]  in_slot;
  logic [31:0] in_x, in_y;
  logic [15:0] in_z, in_w;
  logic        in_accept;

  assign in_slot   = in_tdata[3:0];
  assign in_x      = in_tdata[35:4];
  assign in_y      = in_tdata[67:36];
  assign in_z      = in_tdata[83:68];
  assign in_w      = in_tdata[99:84];
  assign in_accept = in_tvalid && in_tready;

  // configuration
  logic [39:0] arrival_r;
  logic [4:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= ARRIVAL_RESET;
      count_r   <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ARRIVAL: arrival_r <= cfg_wdata;
        CFG_COUNT:   count_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // count clamped to 1..MAX_WAYPOINTS
  logic [CMP_W-1:0] count_ext;
  logic [CNT_W-1:0] cnt_act;

  always_comb begin
    count_ext = CMP_W'(count_r);
    if (count_ext == '0) begin
      cnt_act = CNT_W'(1);
    end else if (count_ext > CMP_W'(MAX_WAYPOINTS)) begin
      cnt_act = CNT_W'(MAX_WAYPOINTS);
    end else begin
      cnt_act = CNT_W'(count_ext);
    end
  end

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] s,
                                                 input logic [CNT_W-1:0] cnt);
    logic [WR_W-1:0] n;
    n = WR_W'(s) + WR_W'(1);
    return (n >= WR_W'(cnt)) ? '0 : IDX_W'(n);
  endfunction

  // waypoint ram: {w, z, y, x}
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  logic [31:0]      rd_x, rd_y;

  assign ram_we    = in_accept && (in_tuser == ACT_LOAD) &&
                     (32'(in_slot) < 32'(MAX_WAYPOINTS));
  assign ram_waddr = IDX_W'(in_slot);
  assign rd_x      = ram_rdata[31:0];
  assign rd_y      = ram_rdata[63:32];

  wps_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_WAYPOINTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({in_w, in_z, in_y, in_x}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control state
  wps_state_t       state_r, state_nxt;
  logic [31:0]      target_x_r, target_x_nxt, target_y_r, target_y_nxt;
  logic [31:0]      robot_x_r, robot_x_nxt, robot_y_r, robot_y_nxt;
  logic             seen_r, seen_nxt, started_r, started_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt, scan_idx_r, scan_idx_nxt, pick_r, pick_nxt;
  logic [63:0]      best_r, best_nxt;
  logic             rd_issue;
  logic             out_valid_r, out_valid_nxt, out_load;

  // distance pipe
  logic             rd_vld_r, mag_vld_r, sq_vld_r, dist_vld_r;
  logic [IDX_W-1:0] rd_idx_r, mag_idx_r, sq_idx_r, dist_idx_r;
  logic [31:0]      mag_x_r, mag_y_r;
  logic [63:0]      sq_x_r, sq_y_r, dist_r;
  logic             arr_start, mag_load;
  logic [31:0]      src_x, src_y;
  logic [32:0]      diff_x, diff_y;
  logic [64:0]      sq_sum;

  assign arr_start = in_accept && (in_tuser == ACT_TICK) && seen_r;
  assign mag_load  = arr_start || rd_vld_r;
  assign src_x     = arr_start ? target_x_r : rd_x;
  assign src_y     = arr_start ? target_y_r : rd_y;
  assign diff_x    = {src_x[31], src_x} - {robot_x_r[31], robot_x_r};
  assign diff_y    = {src_y[31], src_y} - {robot_y_r[31], robot_y_r};
  assign sq_sum    = {1'b0, sq_x_r} + {1'b0, sq_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      mag_vld_r  <= 1'b0;
      sq_vld_r   <= 1'b0;
      dist_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= rd_issue;
      mag_vld_r  <= mag_load;
      sq_vld_r   <= mag_vld_r;
      dist_vld_r <= sq_vld_r;
    end
    rd_idx_r   <= scan_idx_r;
    mag_idx_r  <= rd_idx_r;
    sq_idx_r   <= mag_idx_r;
    dist_idx_r <= sq_idx_r;
    mag_x_r    <= diff_x[32] ? 32'(-diff_x) : diff_x[31:0];
    mag_y_r    <= diff_y[32] ? 32'(-diff_y) : diff_y[31:0];
    sq_x_r     <= 64'(mag_x_r) * 64'(mag_x_r);
    sq_y_r     <= 64'(mag_y_r) * 64'(mag_y_r);
    // saturate at 2^64-1
    dist_r     <= sq_sum[64] ? '1 : sq_sum[63:0];
  end

  // output register
  logic [31:0]      out_x_r, out_y_r;
  logic [15:0]      out_z_r, out_w_r;
  logic [IDX_W-1:0] out_slot_r;

  always_comb begin
    state_nxt     = state_r;
    target_x_nxt  = target_x_r;
    target_y_nxt  = target_y_r;
    robot_x_nxt   = robot_x_r;
    robot_y_nxt   = robot_y_r;
    seen_nxt      = seen_r;
    started_nxt   = started_r;
    cur_nxt       = cur_r;
    scan_idx_nxt  = scan_idx_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    rd_issue      = 1'b0;
    ram_raddr     = scan_idx_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;

    // nearest-entry tracking, first strictly smaller distance wins
    if ((state_r == ST_SCAN || state_r == ST_DRAIN) && dist_vld_r && dist_r < best_r) begin
      best_nxt = dist_r;
      cur_nxt  = dist_idx_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_tuser)
            ACT_GOAL: begin
              target_x_nxt = in_x;
              target_y_nxt = in_y;
              seen_nxt     = 1'b1;
            end
            ACT_POSE: begin
              robot_x_nxt = in_x;
              robot_y_nxt = in_y;
            end
            ACT_TICK: begin
              if (seen_r) begin
                state_nxt = ST_ARRIVE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ARRIVE: begin
        if (dist_vld_r) begin
          if (dist_r > {24'd0, arrival_r}) begin
            state_nxt = ST_IDLE;
          end else if (started_r) begin
            cur_nxt   = wrap_next(cur_r, cnt_act);
            pick_nxt  = cur_nxt;
            ram_raddr = cur_nxt;
            state_nxt = ST_FETCH;
          end else begin
            best_nxt     = SCAN_START_SQ;
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_issue     = 1'b1;
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (CNT_W'(scan_idx_r) == cnt_act - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mag_vld_r && !sq_vld_r && !dist_vld_r) begin
          pick_nxt    = wrap_next(cur_r, cnt_act);
          ram_raddr   = pick_nxt;
          started_nxt = 1'b1;
          state_nxt   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        ram_raddr = pick_r;
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          target_x_nxt  = rd_x;
          target_y_nxt  = rd_y;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_x_r  <= '0;
      target_y_r  <= '0;
      robot_x_r   <= '0;
      robot_y_r   <= '0;
      seen_r      <= 1'b0;
      started_r   <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_x_r  <= target_x_nxt;
      target_y_r  <= target_y_nxt;
      robot_x_r   <= robot_x_nxt;
      robot_y_r   <= robot_y_nxt;
      seen_r      <= seen_nxt;
      started_r   <= started_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r <= scan_idx_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    if (out_load) begin
      out_x_r    <= rd_x;
      out_y_r    <= rd_y;
      out_z_r    <= ram_rdata[79:64];
      out_w_r    <= ram_rdata[95:80];
      out_slot_r <= pick_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, 4'(out_slot_r), out_w_r, out_z_r, out_y_r, out_x_r};

endmodule

`default_nettype wire

### hdl/wps_checker.sv
// port-level checker for the patrol sequencer, bound to the top level
`default_nettype none

`include "waypoint_patrol_sequencer_unit_macros.svh"

module wps_checker
  import wps_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic [IN_TUSER_W-1:0]  in_tuser,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready
);

  // a stalled result word holds
  `WPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result word changed")

  // after a load, set goal or pose update the input is ready again in the next cycle
  `WPS_ASSERT_NXT(a_quick_items, clk, rst_n, in_tvalid && in_tready && in_tuser != ACT_TICK, in_tready, "non-tick word kept the input stalled")

  // a result appears only at the end of tick work
  `WPS_ASSERT_IMP(a_out_after_work, clk, rst_n, $rose(out_tvalid), $past(!in_tready), "result word without tick processing")

  // no result right out of reset
  `WPS_ASSERT_IMP(a_reset_quiet, clk, rst_n, !$past(rst_n), !out_tvalid, "result word valid after reset")

endmodule

bind waypoint_patrol_sequencer_unit wps_checker u_wps_checker (.*);

`default_nettype wire

### tb/sv/waypoint_patrol_sequencer_unit_checker.sv
// checker of the patrol sequencer: watches the channels, predicts goals and compares them
module waypoint_patrol_sequencer_unit_checker
  import wps_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  // slot, pos_x, pos_y, orient_z, orient_w, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // goal_x, goal_y, goal_z, goal_w, goal_slot, zero pad
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          pending,
  output int                          goals_seen
);

  localparam int TABLE_DEPTH = 16;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] z;
    logic [15:0] w;
    logic [3:0]  slot;
  } goal_t;

  goal_t expected_goals[$];

  logic [31:0] wp_x[TABLE_DEPTH];
  logic [31:0] wp_y[TABLE_DEPTH];
  logic [15:0] wp_z[TABLE_DEPTH];
  logic [15:0] wp_w[TABLE_DEPTH];
  logic [31:0] tgt_x, tgt_y, pose_x, pose_y;
  logic        has_goal, patrolling;
  int          last_slot;
  logic [39:0] arrive_sq;
  logic [4:0]  loop_len;

  initial begin
    fail_count = 0;
    pending    = 0;
    goals_seen = 0;
  end

  function automatic logic [63:0] sq_delta(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    logic [63:0]        m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  // squared distance in Q32.32, saturating
  function automatic logic [63:0] dist2(logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] bx, logic [31:0] by);
    logic [64:0] s;
    s = {1'b0, sq_delta(ax, bx)} + {1'b0, sq_delta(ay, by)};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic int loop_size();
    int n;
    n = int'(loop_len);
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic int step_slot(int s, int n);
    return (s + 1 >= n) ? 0 : s + 1;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic predict_word(wps_action_t act, logic [IN_TDATA_W-1:0] d);
    logic [3:0]  slot;
    logic [31:0] px, py;
    logic [63:0] best, dd;
    int          n, pick;
    goal_t       g;
    slot = d[3:0];
    px   = d[35:4];
    py   = d[67:36];
    case (act)
      ACT_LOAD: begin
        wp_x[slot] = px;
        wp_y[slot] = py;
        wp_z[slot] = d[83:68];
        wp_w[slot] = d[99:84];
      end
      ACT_GOAL: begin
        tgt_x    = px;
        tgt_y    = py;
        has_goal = 1'b1;
      end
      ACT_POSE: begin
        pose_x = px;
        pose_y = py;
      end
      default: begin
        if (has_goal && dist2(tgt_x, tgt_y, pose_x, pose_y) <= {24'd0, arrive_sq}) begin
          n = loop_size();
          if (!patrolling) begin
            // nearest entry first, then the one after it
            best = SCAN_START_SQ;
            for (int i = 0; i < n; i++) begin
              dd = dist2(wp_x[i], wp_y[i], pose_x, pose_y);
              if (dd < best) begin
                best      = dd;
                last_slot = i;
              end
            end
            patrolling = 1'b1;
            pick = step_slot(last_slot, n);
          end else begin
            last_slot = step_slot(last_slot, n);
            pick      = last_slot;
          end
          tgt_x  = wp_x[pick];
          tgt_y  = wp_y[pick];
          g.x    = wp_x[pick];
          g.y    = wp_y[pick];
          g.z    = wp_z[pick];
          g.w    = wp_w[pick];
          g.slot = pick[3:0];
          expected_goals.push_back(g);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    goal_t want;
    if (!rst_n) begin
      expected_goals.delete();
      tgt_x      = '0;
      tgt_y      = '0;
      pose_x     = '0;
      pose_y     = '0;
      has_goal   = 1'b0;
      patrolling = 1'b0;
      last_slot  = 0;
      arrive_sq  = ARRIVAL_RESET;
      loop_len   = COUNT_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        goals_seen++;
        if (expected_goals.size() == 0) begin
          $display("goal word with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_goals.pop_front();
          if (out_tdata[31:0] !== want.x) begin
            flag_mismatch("goal_x", 64'(out_tdata[31:0]), 64'(want.x));
          end
          if (out_tdata[63:32] !== want.y) begin
            flag_mismatch("goal_y", 64'(out_tdata[63:32]), 64'(want.y));
          end
          if (out_tdata[79:64] !== want.z) begin
            flag_mismatch("goal_z", 64'(out_tdata[79:64]), 64'(want.z));
          end
          if (out_tdata[95:80] !== want.w) begin
            flag_mismatch("goal_w", 64'(out_tdata[95:80]), 64'(want.w));
          end
          if (out_tdata[99:96] !== want.slot) begin
            flag_mismatch("goal_slot", 64'(out_tdata[99:96]), 64'(want.slot));
          end
        end
      end
      if (in_tvalid && in_tready) predict_word(wps_action_t'(in_tuser), in_tdata);
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_ARRIVAL) arrive_sq = cfg_wdata;
        else if (cfg_addr == CFG_COUNT) loop_len = cfg_wdata[4:0];
      end
    end
    pending <= expected_goals.size();
  end

endmodule

### tb/sv/waypoint_patrol_sequencer_unit_tb.sv
// testbench top of the patrol sequencer: clock, reset, stimulus and verdict
module waypoint_patrol_sequencer_unit_tb
  import wps_pkg::*;
();

  localparam int ONE_M     = 65536;
  localparam int SETTLE    = 40;
  localparam int PHASE_LEN = 200;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int fail_count, pending, goals_seen;
  int words_sent  = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  bit hold_armed  = 1'b0;
  bit hold_done   = 1'b0;

  // positions the stimulus has loaded, used to aim poses, goals and a duplicate load near waypoints
  logic [31:0] shadow_x[16];
  logic [31:0] shadow_y[16];

  waypoint_patrol_sequencer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  waypoint_patrol_sequencer_unit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .goals_seen (goals_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("timeout with %0d goals outstanding", pending);
    $display("Some tests failed");
    $finish;
  end

  // receiver: changing stall modes, plus one long hold-off
  initial begin
    int mode, mode_left, hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (!rst_n || hold_left > 0) begin
        if (hold_left > 0) hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] area_coord();
    return $urandom_range(0, 12 * ONE_M) - 6 * ONE_M;
  endfunction

  function automatic logic [31:0] jitter();
    if ($urandom_range(0, 2) == 0) return '0;
    return $urandom_range(0, 80000) - 40000;
  endfunction

  // one word on the input stream; bursts with random gaps between them
  task automatic send_word(wps_action_t act, logic [3:0] slot, logic [31:0] x,
                           logic [31:0] y, logic [15:0] z, logic [15:0] w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'd0, w, z, y, x, slot};
    do @(posedge clk); while (!in_tready);
    if (act == ACT_LOAD) begin
      shadow_x[slot] = x;
      shadow_y[slot] = y;
    end
    words_sent++;
  endtask

  task automatic send_plain(wps_action_t act, logic [31:0] x, logic [31:0] y);
    send_word(act, 4'($urandom), x, y, 16'($urandom), 16'($urandom));
  endtask

  // drop valid and wait until every goal is out and the block has gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic patrol_mix(int n_items);
    int          done, k, pick;
    logic [31:0] px, py;
    done = 0;
    while (done < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        // visit: optional goal, pose near a waypoint, tick
        pick = $urandom_range(0, 15);
        px = shadow_x[pick] + jitter();
        py = shadow_y[pick] + jitter();
        if ($urandom_range(0, 2) == 0) begin
          send_plain(ACT_GOAL, px, py);
          done++;
        end
        send_plain(ACT_POSE, px + jitter(), py + jitter());
        send_plain(ACT_TICK, $urandom, $urandom);
        done += 2;
        if ($urandom_range(0, 3) == 0) begin
          send_plain(ACT_TICK, $urandom, $urandom);
          done++;
        end
      end else if (k < 60) begin
        send_word(ACT_LOAD, 4'($urandom), area_coord(), area_coord(),
                  16'($urandom), 16'($urandom));
        done++;
      end else if (k < 70) begin
        // noise: any action, full-range fields
        send_word(wps_action_t'($urandom_range(0, 3)), 4'($urandom), $urandom, $urandom,
                  16'($urandom), 16'($urandom));
        done++;
      end else if (k < 85) begin
        send_plain(ACT_TICK, $urandom, $urandom);
        done++;
      end else begin
        pick = $urandom_range(0, 15);
        send_plain(ACT_POSE, shadow_x[pick] + jitter(), shadow_y[pick] + jitter());
        done++;
      end
    end
  endtask

  initial begin
    logic [31:0] gx, gy, fx, fy;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with no goal yet
    send_plain(ACT_TICK, $urandom, $urandom);
    // fill the whole table, extremes in the end slots
    send_word(ACT_LOAD, 4'd0, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000);
    for (int i = 1; i < 15; i++) begin
      send_word(ACT_LOAD, 4'(i), area_coord(), area_coord(), 16'($urandom), 16'($urandom));
    end
    send_word(ACT_LOAD, 4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF);
    // a duplicate entry, so the scan sees a tie
    send_word(ACT_LOAD, 4'd7, shadow_x[2], shadow_y[2], 16'($urandom), 16'($urandom));
    // opposite corners: the squared sum saturates
    send_plain(ACT_GOAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_plain(ACT_POSE, 32'h8000_0000, 32'h8000_0000);
    send_plain(ACT_TICK, $urandom, $urandom);
    // first emission near entry 2, or far from every entry
    if ($urandom_range(0, 2) == 0) begin
      gx = 20000 * ONE_M;
      gy = -20000 * ONE_M;
    end else begin
      gx = shadow_x[2] + jitter();
      gy = shadow_y[2] + jitter();
    end
    send_plain(ACT_GOAL, gx, gy);
    // one lsb beyond the 1.0 threshold, then exactly on it
    send_plain(ACT_POSE, gx + ONE_M + 1, gy);
    send_plain(ACT_TICK, $urandom, $urandom);
    send_plain(ACT_POSE, gx + ONE_M, gy);
    send_plain(ACT_TICK, $urandom, $urandom);
    patrol_mix(PHASE_LEN);
    drain();

    // widest threshold, full loop, receiver holds off for a while
    write_reg(CFG_ARRIVAL, '1);
    write_reg(CFG_COUNT, CFG_DATA_W'(16));
    hold_armed = 1'b1;
    patrol_mix(PHASE_LEN);
    drain();

    // exact arrival only, single waypoint loop
    write_reg(CFG_ARRIVAL, '0);
    write_reg(CFG_COUNT, CFG_DATA_W'(1));
    for (int i = 0; i < PHASE_LEN / 5; i++) begin
      fx = area_coord();
      fy = area_coord();
      send_plain(ACT_GOAL, fx, fy);
      send_plain(ACT_POSE, fx, fy);
      send_plain(ACT_TICK, $urandom, $urandom);
    end
    patrol_mix(PHASE_LEN / 2);
    drain();

    // count of zero acts as one
    write_reg(CFG_ARRIVAL, {8'($urandom), 32'($urandom)});
    write_reg(CFG_COUNT, CFG_DATA_W'(0));
    patrol_mix(PHASE_LEN);
    drain();

    // count above the table size
    write_reg(CFG_ARRIVAL, ARRIVAL_RESET);
    write_reg(CFG_COUNT, CFG_DATA_W'(31));
    patrol_mix(PHASE_LEN);
    drain();

    write_reg(CFG_ARRIVAL, {4'd0, 4'($urandom), 32'($urandom)});
    write_reg(CFG_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
    patrol_mix(PHASE_LEN);
    drain();

    write_reg(CFG_ARRIVAL, '1);
    write_reg(CFG_COUNT, CFG_DATA_W'(5));
    patrol_mix(PHASE_LEN);
    drain();

    $display("sent %0d words over %0d register writes; %0d goals came out and were checked",
             words_sent, cfg_writes, goals_seen);
    $display("covered loop sizes 0, 1, 5, 16, 31 and thresholds from zero to full scale");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
